### rtl/upc_pkg.sv
// Shared constants and an elaboration-time helper for the unit circle projection unit.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package upc_pkg;

   // Default parameter values of the top level
   localparam int DEF_DATA_WIDTH    = 16;
   localparam int DEF_CORDIC_STAGES = 16;
   localparam int DEF_INDEX_BITS    = 16;

   // Fixed-point layout
   localparam int GUARD_BITS     = 24;   // fraction bits added before vectoring
   localparam int OUT_WIDTH      = 16;   // Q2.14 result words
   localparam int OUT_FRAC       = 14;
   localparam int ONE_Q14        = 16384;
   localparam int ROT_WIDTH      = 33;   // rotation datapath, signed
   localparam int ROT_START_EXP  = 30;   // rotation starts from (2^30, 0)
   localparam int MAG_WIDTH      = 32;   // magnitude of a rotation result
   localparam int GAIN_WIDTH     = 31;   // CORDIC gain constant K
   localparam int RECIP_WIDTH    = 16;   // reciprocal of K, scaled
   localparam int RECIP_SHIFT    = 32;
   localparam int QEST_WIDTH     = 16;   // quotient estimate
   localparam int NUM_WIDTH      = 48;   // dividend and quotient-times-K

   // Scaled CORDIC gain: floor(sqrt(2^60 * prod(1 + 2^-2i))), truncating each step
   function automatic longint unsigned upc_gain(input int stages);
      longint unsigned k2;
      longint unsigned rem_v;
      longint unsigned res;
      longint unsigned bit_v;
      int              i;
      k2 = 64'd1 << 60;
      for (i = 0; i < stages; i++) begin
         k2 = k2 + (k2 >> (2 * i));
      end
      rem_v = k2;
      res   = 64'd0;
      bit_v = 64'd1 << 62;
      while (bit_v > rem_v) begin
         bit_v = bit_v >> 2;
      end
      while (bit_v != 64'd0) begin
         if (rem_v >= res + bit_v) begin
            rem_v = rem_v - (res + bit_v);
            res   = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/upc_req_if.sv
// Request channel of the unit circle projection unit: one point and its row tag per word.
// Depends on upc_pkg for default widths.
`default_nettype none

interface upc_req_if import upc_pkg::*; #(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int INDEX_BITS = DEF_INDEX_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] x_in;
   logic signed [DATA_WIDTH-1:0] y_in;
   logic        [INDEX_BITS-1:0] point_index;

   modport source (output valid, output x_in, output y_in, output point_index, input ready);
   modport sink   (input valid, input x_in, input y_in, input point_index, output ready);
endinterface

`default_nettype wire

### rtl/upc_rsp_if.sv
// Response channel of the unit circle projection unit: unit vector in Q2.14 and row tag.
// Depends on upc_pkg for the result width and default tag width.
`default_nettype none

interface upc_rsp_if import upc_pkg::*; #(
   parameter int INDEX_BITS = DEF_INDEX_BITS
);
   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] unit_x;
   logic signed [OUT_WIDTH-1:0] unit_y;
   logic        [INDEX_BITS-1:0] index_out;

   modport source (output valid, output unit_x, output unit_y, output index_out, input ready);
   modport sink   (input valid, input unit_x, input unit_y, input index_out, output ready);
endinterface

`default_nettype wire

### rtl/unit_circle_projection_unit.sv
// Top level of the unit circle projection unit: CORDIC vectoring/rotation pipeline and
// constant-reciprocal scaling. Depends on upc_pkg, upc_req_if and upc_rsp_if.
`default_nettype none

// Projects each point (x_in, y_in) onto the unit circle and returns cos and sin of its
// argument in signed Q2.14 (16384 = 1.0), with point_index passed through as index_out.
// A zero point gives (16384, 0). One word is accepted every cycle while req_ch.ready is
// high. The pipeline has one preparation stage, one stage per CORDIC iteration (each
// does a vectoring step and the matching rotation step of the unit vector), and four
// stages that divide out the CORDIC gain by a constant reciprocal multiply and a
// correction of the estimate by up to two. The output is followed by a one-word skid
// register, so the pipeline keeps accepting while a finished result waits; req_ch.ready
// drops only once that register is full, and comes straight from a flip-flop.
module unit_circle_projection_unit import upc_pkg::*; #(
   parameter int DATA_WIDTH    = DEF_DATA_WIDTH,
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
   parameter int INDEX_BITS    = DEF_INDEX_BITS
) (
   input  logic      clock,
   input  logic      reset,
   upc_req_if.sink   req_ch,
   upc_rsp_if.source rsp_ch
);

   localparam int VW     = DATA_WIDTH + GUARD_BITS + 4;
   localparam int S_D1   = CORDIC_STAGES + 1;
   localparam int S_D2   = CORDIC_STAGES + 2;
   localparam int S_D3   = CORDIC_STAGES + 3;
   localparam int S_OUT  = CORDIC_STAGES + 4;
   localparam int NS     = CORDIC_STAGES + 5;

   localparam longint unsigned GAIN_K = upc_gain(CORDIC_STAGES);
   localparam logic [GAIN_WIDTH-1:0]  K_VAL     = GAIN_WIDTH'(GAIN_K);
   localparam logic [GAIN_WIDTH:0]    K_TWICE   = (GAIN_WIDTH + 1)'(GAIN_K << 1);
   localparam logic [GAIN_WIDTH-1:0]  HALF_K    = GAIN_WIDTH'(GAIN_K >> 1);
   localparam logic [RECIP_WIDTH-1:0] RECIP_VAL =
      RECIP_WIDTH'((64'd1 << (OUT_FRAC + RECIP_SHIFT)) / GAIN_K);
   localparam logic signed [ROT_WIDTH-1:0] ROT_START = ROT_WIDTH'(64'd1 << ROT_START_EXP);
   localparam logic [OUT_WIDTH:0]     Q_ONE     = (OUT_WIDTH + 1)'(ONE_Q14);

   // Pipeline control
   logic              en;
   logic [NS-1:0]     vld_ff;

   // Vectoring and rotation datapath, index 0 is the preparation stage
   logic signed [VW-1:0]        vx_ff [0:CORDIC_STAGES];
   logic signed [VW-1:0]        vy_ff [0:CORDIC_STAGES];
   logic signed [ROT_WIDTH-1:0] rx_ff [0:CORDIC_STAGES];
   logic signed [ROT_WIDTH-1:0] ry_ff [0:CORDIC_STAGES];

   // Side band carried alongside
   logic                  flip_ff [0:S_D3];
   logic                  zero_ff [0:S_D3];
   logic [INDEX_BITS-1:0] tag_ff  [0:S_OUT];

   // Scaling stages, one entry per axis (0 = x, 1 = y)
   logic signed [ROT_WIDTH-1:0]   rot_res [2];
   logic                          neg1_ff [2];
   logic [MAG_WIDTH-1:0]          mag1_ff [2];
   logic                          neg2_ff [2];
   logic [MAG_WIDTH-1:0]          mag2_ff [2];
   logic [QEST_WIDTH-1:0]         qe2_ff  [2];
   logic                          neg3_ff [2];
   logic [QEST_WIDTH-1:0]         qe3_ff  [2];
   logic [NUM_WIDTH-1:0]          num3_ff [2];
   logic [NUM_WIDTH-1:0]          prod3_ff[2];
   logic signed [OUT_WIDTH-1:0]   res_in  [2];
   logic signed [OUT_WIDTH-1:0]   res_ff  [2];

   // Skid register behind the output stage
   logic                        skid_vld_ff;
   logic signed [OUT_WIDTH-1:0] skid_x_ff;
   logic signed [OUT_WIDTH-1:0] skid_y_ff;
   logic [INDEX_BITS-1:0]       skid_tag_ff;

   // Preparation stage signals
   logic signed [VW-1:0] prep_x;
   logic signed [VW-1:0] prep_y;
   logic                 prep_flip;
   logic                 prep_zero;

   // Advance the whole pipeline while the skid register is empty
   assign en           = !skid_vld_ff;
   assign req_ch.ready = en;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], req_ch.valid};
      end
   end

   // Fold the left half-plane onto the right one and add guard bits
   always_comb begin
      prep_flip = req_ch.x_in[DATA_WIDTH-1];
      prep_zero = (req_ch.x_in == '0) && (req_ch.y_in == '0);
      prep_x    = VW'(req_ch.x_in);
      prep_y    = VW'(req_ch.y_in);
      if (prep_flip) begin
         prep_x = -prep_x;
         prep_y = -prep_y;
      end
      prep_x = prep_x <<< GUARD_BITS;
      prep_y = prep_y <<< GUARD_BITS;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff[0]   <= prep_x;
         vy_ff[0]   <= prep_y;
         rx_ff[0]   <= ROT_START;
         ry_ff[0]   <= '0;
         flip_ff[0] <= prep_flip;
         zero_ff[0] <= prep_zero;
         tag_ff[0]  <= req_ch.point_index;
      end
   end

   // One vectoring step and the matching rotation step per stage
   for (genvar gs = 1; gs <= CORDIC_STAGES; gs++) begin : g_cordic
      logic                        dir;
      logic signed [VW-1:0]        vx_sh;
      logic signed [VW-1:0]        vy_sh;
      logic signed [ROT_WIDTH-1:0] rx_sh;
      logic signed [ROT_WIDTH-1:0] ry_sh;

      always_comb begin
         dir   = !vy_ff[gs-1][VW-1];
         vx_sh = vx_ff[gs-1] >>> (gs - 1);
         vy_sh = vy_ff[gs-1] >>> (gs - 1);
         rx_sh = rx_ff[gs-1] >>> (gs - 1);
         ry_sh = ry_ff[gs-1] >>> (gs - 1);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (dir) begin
               vx_ff[gs] <= vx_ff[gs-1] + vy_sh;
               vy_ff[gs] <= vy_ff[gs-1] - vx_sh;
               rx_ff[gs] <= rx_ff[gs-1] - ry_sh;
               ry_ff[gs] <= ry_ff[gs-1] + rx_sh;
            end else begin
               vx_ff[gs] <= vx_ff[gs-1] - vy_sh;
               vy_ff[gs] <= vy_ff[gs-1] + vx_sh;
               rx_ff[gs] <= rx_ff[gs-1] + ry_sh;
               ry_ff[gs] <= ry_ff[gs-1] - rx_sh;
            end
         end
      end
   end

   // Carry side band through the pipeline
   for (genvar gt = 1; gt <= S_OUT; gt++) begin : g_tag
      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[gt] <= tag_ff[gt-1];
         end
      end
   end

   for (genvar gf = 1; gf <= S_D3; gf++) begin : g_flag
      always_ff @(posedge clock) begin
         if (en) begin
            flip_ff[gf] <= flip_ff[gf-1];
            zero_ff[gf] <= zero_ff[gf-1];
         end
      end
   end

   assign rot_res[0] = rx_ff[CORDIC_STAGES];
   assign rot_res[1] = ry_ff[CORDIC_STAGES];

   // Divide each axis by the CORDIC gain, round half away from zero, saturate; a zero point gives (1.0, 0)
   for (genvar ga = 0; ga < 2; ga++) begin : g_axis
      logic [MAG_WIDTH+RECIP_WIDTH-1:0] recip_prod;
      logic signed [NUM_WIDTH:0]        rem1;
      logic signed [NUM_WIDTH:0]        rem2;
      logic [QEST_WIDTH:0]              quot;
      logic [OUT_WIDTH:0]               quot_sat;

      assign recip_prod = (MAG_WIDTH + RECIP_WIDTH)'(mag1_ff[ga]) *
                          (MAG_WIDTH + RECIP_WIDTH)'(RECIP_VAL);

      // Take magnitude and sign
      always_ff @(posedge clock) begin
         if (en) begin
            neg1_ff[ga] <= rot_res[ga][ROT_WIDTH-1];
            mag1_ff[ga] <= rot_res[ga][ROT_WIDTH-1] ? MAG_WIDTH'(-rot_res[ga])
                                                    : MAG_WIDTH'(rot_res[ga]);
         end
      end

      // Estimate the quotient from the reciprocal
      always_ff @(posedge clock) begin
         if (en) begin
            neg2_ff[ga] <= neg1_ff[ga];
            mag2_ff[ga] <= mag1_ff[ga];
            qe2_ff[ga]  <= recip_prod[MAG_WIDTH+RECIP_WIDTH-1:RECIP_SHIFT];
         end
      end

      // Form the rounded dividend and the estimate times K
      always_ff @(posedge clock) begin
         if (en) begin
            neg3_ff[ga]  <= neg2_ff[ga];
            qe3_ff[ga]   <= qe2_ff[ga];
            num3_ff[ga]  <= (NUM_WIDTH'(mag2_ff[ga]) << OUT_FRAC) + NUM_WIDTH'(HALF_K);
            prod3_ff[ga] <= NUM_WIDTH'(qe2_ff[ga]) * NUM_WIDTH'(K_VAL);
         end
      end

      // Correct the estimate by up to two, then saturate and restore the sign
      always_comb begin
         rem1 = $signed({1'b0, num3_ff[ga]}) - $signed({1'b0, prod3_ff[ga]})
              - $signed((NUM_WIDTH + 1)'(K_VAL));
         rem2 = $signed({1'b0, num3_ff[ga]}) - $signed({1'b0, prod3_ff[ga]})
              - $signed((NUM_WIDTH + 1)'(K_TWICE));
         quot = (QEST_WIDTH + 1)'(qe3_ff[ga]) + (QEST_WIDTH + 1)'(!rem1[NUM_WIDTH])
              + (QEST_WIDTH + 1)'(!rem2[NUM_WIDTH]);
         quot_sat = ((OUT_WIDTH + 1)'(quot) > Q_ONE) ? Q_ONE : (OUT_WIDTH + 1)'(quot);
         if (zero_ff[S_D3]) begin
            res_in[ga] = (ga == 0) ? OUT_WIDTH'(ONE_Q14) : '0;
         end else if (neg3_ff[ga] ^ flip_ff[S_D3]) begin
            res_in[ga] = -$signed(OUT_WIDTH'(quot_sat));
         end else begin
            res_in[ga] = $signed(OUT_WIDTH'(quot_sat));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            res_ff[ga] <= res_in[ga];
         end
      end
   end

   // Catch the output word when it stalls, drain it when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (!skid_vld_ff) begin
         skid_vld_ff <= vld_ff[S_OUT] && !rsp_ch.ready;
      end else if (rsp_ch.ready) begin
         skid_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_x_ff   <= res_ff[0];
         skid_y_ff   <= res_ff[1];
         skid_tag_ff <= tag_ff[S_OUT];
      end
   end

   assign rsp_ch.valid     = skid_vld_ff || vld_ff[S_OUT];
   assign rsp_ch.unit_x    = skid_vld_ff ? skid_x_ff   : res_ff[0];
   assign rsp_ch.unit_y    = skid_vld_ff ? skid_y_ff   : res_ff[1];
   assign rsp_ch.index_out = skid_vld_ff ? skid_tag_ff : tag_ff[S_OUT];

   // Results never leave the unit circle range
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ($signed(rsp_ch.unit_x) <= ONE_Q14 && $signed(rsp_ch.unit_x) >= -ONE_Q14
                     && $signed(rsp_ch.unit_y) <= ONE_Q14 && $signed(rsp_ch.unit_y) >= -ONE_Q14))
      else $error("unit vector component out of range");

   // The reciprocal estimate never overshoots the true quotient
   a_quot_est: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_D3] |-> (num3_ff[0] >= prod3_ff[0] && num3_ff[1] >= prod3_ff[1]))
      else $error("quotient estimate too large");

   // The skid register fills only from a stalled output word
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(vld_ff[S_OUT] && !rsp_ch.ready))
      else $error("skid register filled without a stalled word");

endmodule

`default_nettype wire
